// ===== src/lru_pkg.sv =====
// Shared types and constants for the LRU list block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lru_pkg;
  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_TOUCH  = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_POP    = 3'd3;
  localparam logic [2:0] ACT_PURGE  = 3'd4;
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_LISTED  = 2'd2;
  localparam int MAX_RESULTS = 32;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE, OP_UNLINK, OP_LINK, OP_CLEAR, OP_SETMARK
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       use_tail;   // operate on tail slot instead of request slot
    logic       capture;    // latch operand slot (tail or request)
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] length;
    logic       tail_root;
    logic       valid;      // request slot lies within the entry range
    logic       present;
    logic       head_hit;
    logic [4:0] op_slot;
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== src/lru_datapath.sv =====
// Datapath: link arrays, listed/root flags, head, tail and length.
// Depends on lru_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lru_datapath #(
  parameter int ENTRIES = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [4:0]       req_slot,
  input  wire logic             req_root,
  input  wire lru_pkg::dp_cmd_t cmd,
  output lru_pkg::dp_stat_t     stat
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  logic [ENTRIES-1:0] listed_r, root_r;
  logic [IW-1:0] th_r [ENTRIES];
  logic [IW-1:0] tt_r [ENTRIES];
  logic [IW-1:0] head_r, tail_r, slot_r;
  logic [5:0] len_r;
  logic [IW-1:0] s, p, n, rs;
  logic rvalid;

  assign rvalid = (32'(req_slot) < ENTRIES);
  assign rs = IW'(req_slot);
  // operand: latched slot
  assign s = slot_r;
  assign p = th_r[s];
  assign n = tt_r[s];

  assign stat.length    = len_r;
  assign stat.tail_root = root_r[tail_r];
  assign stat.valid     = rvalid;
  assign stat.present   = rvalid && listed_r[rs];
  assign stat.head_hit  = (head_r == rs);
  assign stat.op_slot   = 5'(slot_r);

  // apply one link update per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listed_r <= '0;
      root_r   <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      len_r    <= '0;
      slot_r   <= '0;
    end else begin
      if (cmd.capture) slot_r <= cmd.use_tail ? tail_r : rs;
      unique case (cmd.op)
        lru_pkg::OP_UNLINK: begin
          if (s == head_r) head_r <= n; else tt_r[p] <= n;
          if (s == tail_r) tail_r <= p; else th_r[n] <= p;
          if (len_r != 0) len_r <= len_r - 6'd1;
        end
        lru_pkg::OP_LINK: begin
          th_r[s] <= s;
          if (len_r == 0) begin
            tt_r[s] <= s;
            tail_r  <= s;
          end else begin
            tt_r[s] <= head_r;
            th_r[head_r] <= s;
          end
          head_r <= s;
          len_r  <= len_r + 6'd1;
        end
        lru_pkg::OP_CLEAR: begin
          listed_r[s] <= 1'b0;
          root_r[s]   <= 1'b0;
        end
        lru_pkg::OP_SETMARK: begin
          listed_r[s] <= 1'b1;
          root_r[s]   <= req_root;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/lru_ctrl.sv =====
// Controller: sequences datapath commands per action and forms results.
// Depends on lru_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lru_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic [2:0]        in_action,
  input  wire logic [5:0]        limit,
  input  wire lru_pkg::dp_stat_t stat,
  output lru_pkg::dp_cmd_t       cmd,
  output logic                   busy,
  output logic                   res_valid,
  output logic [15:0]            res_data,
  output logic                   res_last,
  input  wire logic              res_ready
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DEC   = 8'b0000_0010,
    S_ULINK = 8'b0000_0100,
    S_LINK  = 8'b0000_1000,
    S_PTAIL = 8'b0001_0000,
    S_PEVIC = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] act_r;
  logic purge_r, purge_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic rootmv_r, rootmv_nxt;
  logic ev_r, ev_nxt, last_r, last_nxt;
  logic [1:0] st_r, st_nxt;
  logic [4:0] es_r, es_nxt;
  logic more;

  assign busy = (state_r != S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res_data = {2'b00, stat.length, st_r, es_r, ev_r};
  assign res_last = last_r;
  assign more = (stat.length > limit) && (stat.length != 0) &&
                (cnt_r < 6'(lru_pkg::MAX_RESULTS));

  always_comb begin
    state_nxt = state_r; cmd = '0;
    purge_nxt = purge_r; cnt_nxt = cnt_r; rootmv_nxt = rootmv_r;
    ev_nxt = ev_r; last_nxt = last_r; st_nxt = st_r; es_nxt = es_r;
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.capture = 1'b1; state_nxt = S_DEC;
        ev_nxt = 1'b0; es_nxt = '0; st_nxt = lru_pkg::ST_DONE; last_nxt = 1'b1;
        cnt_nxt = '0; purge_nxt = 1'b0;
      end
      S_DEC: begin
        state_nxt = S_OUT;
        priority case (act_r)
          lru_pkg::ACT_ADD:
            if (!stat.valid) st_nxt = lru_pkg::ST_MISSING;
            else if (stat.present) st_nxt = lru_pkg::ST_LISTED;
            else begin cmd.op = lru_pkg::OP_SETMARK; state_nxt = S_LINK; end
          lru_pkg::ACT_TOUCH:
            if (!stat.present) st_nxt = lru_pkg::ST_MISSING;
            else if (!stat.head_hit) begin
              cmd.op = lru_pkg::OP_UNLINK; state_nxt = S_LINK;
            end
          lru_pkg::ACT_REMOVE:
            if (!stat.present) st_nxt = lru_pkg::ST_MISSING;
            else begin cmd.op = lru_pkg::OP_UNLINK; state_nxt = S_FIN; end
          lru_pkg::ACT_POP:
            if (stat.length == 0) st_nxt = lru_pkg::ST_MISSING;
            else begin cmd.capture = 1'b1; cmd.use_tail = 1'b1; state_nxt = S_PTAIL; end
          lru_pkg::ACT_PURGE: begin
            purge_nxt = 1'b1;
            if (more) begin cmd.capture = 1'b1; cmd.use_tail = 1'b1; state_nxt = S_PTAIL; end
          end
          default: ;
        endcase
        rootmv_nxt = 1'b0;
      end
      S_LINK: begin cmd.op = lru_pkg::OP_LINK; state_nxt = S_OUT; end
      S_FIN:  begin cmd.op = lru_pkg::OP_CLEAR; state_nxt = S_OUT; end
      // tail latched; move root to head once if needed
      S_PTAIL: begin
        if (!rootmv_r && stat.length > 6'd1 && stat.tail_root) begin
          cmd.op = lru_pkg::OP_UNLINK; state_nxt = S_ULINK; rootmv_nxt = 1'b1;
        end else begin
          cmd.op = lru_pkg::OP_UNLINK; state_nxt = S_PEVIC;
        end
      end
      // relink root at head and latch the new tail for eviction
      S_ULINK: begin
        cmd.op = lru_pkg::OP_LINK; cmd.capture = 1'b1; cmd.use_tail = 1'b1;
        state_nxt = S_PTAIL; rootmv_nxt = 1'b1;
      end
      // clear the evicted slot and decide whether purge goes on
      S_PEVIC: begin
        cmd.op = lru_pkg::OP_CLEAR; state_nxt = S_OUT;
        ev_nxt = 1'b1; es_nxt = stat.op_slot; cnt_nxt = cnt_r + 6'd1;
        if (purge_r)
          last_nxt = !((stat.length > limit) && (stat.length != 0) &&
                       (cnt_r < 6'(lru_pkg::MAX_RESULTS - 1)));
      end
      S_OUT: begin
        if (res_ready) begin
          if (purge_r && ev_r && !last_r) begin
            cmd.capture = 1'b1; cmd.use_tail = 1'b1; rootmv_nxt = 1'b0;
            state_nxt = S_PTAIL;
          end else state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; purge_r <= 1'b0; cnt_r <= '0; rootmv_r <= 1'b0;
      ev_r <= 1'b0; last_r <= 1'b1;
    end else begin
      state_r <= state_nxt; purge_r <= purge_nxt; cnt_r <= cnt_nxt;
      rootmv_r <= rootmv_nxt; ev_r <= ev_nxt; last_r <= last_nxt;
    end
  end
  always_ff @(posedge clk) begin
    st_r <= st_nxt; es_r <= es_nxt;
    if (in_fire && state_r == S_IDLE) act_r <= in_action;
  end
endmodule
`default_nettype wire

// ===== src/lru_list_with_pinned_root.sv =====
// Top level of the LRU list with pinned root: controller plus datapath.
// Depends on lru_pkg, lru_ctrl, lru_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   in_*  : one request per action (add, touch, remove, pop, purge).
//   out_* : one result per request, or one per eviction for purge;
//           out_tlast marks the final result of a request.
//   cfg_* : write purge_limit while idle.
// One request is processed at a time by the controller state machine.
// Each request is decoded first; misses and requests that change nothing then
// give their result; add/touch/remove link, unlink or clear the slot; each
// pop/purge eviction moves a root tail to the head, then unlinks and clears the tail.
// A new request can be accepted in the cycle after the last result is taken.
// The link update engine does one head/tail update per cycle.
// Reset empties the list and sets purge_limit to 32.
// If the receiver stalls, the result holds on out_tdata and no new request
// is accepted until the request's last result is taken.
module lru_list_with_pinned_root #(
  parameter int ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // action[2:0], slot[7:3]
  input  wire logic        in_tuser,   // is_root
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // evicted, evicted_slot, status, list_length, pad
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata
);
  logic [5:0] limit_r;
  logic busy, fire;
  lru_pkg::dp_cmd_t cmd;
  lru_pkg::dp_stat_t stat;
  logic [4:0] slot_r;
  logic root_r;

  assign in_tready = !busy;
  assign fire = in_tvalid && in_tready;

  // hold request slot and root flag
  always_ff @(posedge clk) begin
    if (fire) begin slot_r <= in_tdata[7:3]; root_r <= in_tuser; end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= 6'd32;
    else if (cfg_we) limit_r <= cfg_wdata;
  end

  lru_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .req_slot(fire ? in_tdata[7:3] : slot_r), .req_root(root_r),
    .cmd(cmd), .stat(stat)
  );
  lru_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(fire), .in_action(in_tdata[2:0]),
    .limit(limit_r), .stat(stat), .cmd(cmd), .busy(busy),
    .res_valid(out_tvalid), .res_data(out_tdata), .res_last(out_tlast),
    .res_ready(out_tready)
  );

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    stat.length <= 6'(ENTRIES)) else $error("length overflow");
  a_nofire: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while result pending");
  a_evslot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[5:1] == 5'd0))
    else $error("slot without eviction");
endmodule
`default_nettype wire
